>>> src/wrg_pkg.sv
// wrg_pkg: shared types and constants of the water ripple grid step block
// no dependencies; imported by wrg_ctrl, wrg_dpath, the top level and the checker

package wrg_pkg;

  // field and register widths fixed by the interface
  localparam int CELL_W     = 10;
  localparam int DH_W       = 16;
  localparam int GS_W       = 7;
  localparam int OUT_H_W    = 16;
  localparam int CFG_AW     = 1;
  localparam int CFG_DW     = 16;
  localparam int DAMP_SHIFT = 5;

  // request and result codes
  localparam logic REQ_STEP  = 1'b0;
  localparam logic REQ_READ  = 1'b1;
  localparam logic KIND_STEP = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_DROP_HEIGHT = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_GRID_SIZE   = 1'b1;

  // register reset values
  localparam logic signed [DH_W-1:0] DROP_RESET = 16'sd4096;
  localparam logic [GS_W-1:0]        GS_RESET   = 7'd64;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DROP,
    ST_SWEEP,
    ST_DRAIN,
    ST_ZERO,
    ST_DONE
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;   // latch the item on the input ports
    logic rd_cell;  // read one cell for a read item
    logic rd_a;     // read vertical neighbors and previous value
    logic rd_b;     // read horizontal neighbors
    logic drop;     // write drop height into current bank
    logic clear;    // write zero into both banks
    logic finish;   // load the result registers
    logic swap;     // exchange current and previous banks
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic req_read;
    logic req_drop;
  } stat_t;

endpackage

>>> src/wrg_bank.sv
// wrg_bank: one height bank, one write port and two registered read ports
// no dependencies

module wrg_bank #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [DW-1:0] wd,
  input  logic [AW-1:0] ra0,
  input  logic [AW-1:0] ra1,
  output logic [DW-1:0] rd0,
  output logic [DW-1:0] rd1
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd0 <= mem[ra0];
    rd1 <= mem[ra1];
  end

endmodule

>>> src/wrg_ctrl.sv
// wrg_ctrl: sequencer for clear passes, drop, interior sweep and results
// depends on wrg_pkg

module wrg_ctrl #(
  parameter int GRID_MAX = 64,
  parameter int ADDR_W   = 12,
  parameter int NW       = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [NW-1:0]     n_act,
  input  wrg_pkg::stat_t    st,
  output wrg_pkg::cmd_t     cmd,
  output logic [ADDR_W-1:0] addr
);

  import wrg_pkg::*;

  localparam int CELLS = GRID_MAX * GRID_MAX;
  localparam int RW    = $clog2(GRID_MAX);

  state_t            state_r, state_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [RW-1:0]     col_r, col_nxt;
  logic              ph_r, ph_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [RW-1:0]     lim;
  logic              has_interior;

  assign has_interior = (n_act >= NW'(3));
  assign lim          = RW'(n_act - NW'(2));
  assign busy         = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      row_r   <= '0;
      col_r   <= '0;
      ph_r    <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      ph_r    <= ph_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    ph_nxt    = ph_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    if (state_r == ST_SWEEP) begin
      addr = ADDR_W'(int'(row_r) * GRID_MAX) + ADDR_W'(col_r);
    end else begin
      addr = cnt_r;
    end
    case (state_r)
      ST_CLEAR, ST_ZERO: begin
        cmd.clear = 1'b1;
        if (cnt_r == ADDR_W'(CELLS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = (state_r == ST_CLEAR) ? ST_IDLE : ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          cnt_nxt    = '0;
          if (st.req_read) begin
            cmd.rd_cell = 1'b1;
            state_nxt   = ST_READ;
          end else if (st.req_drop) begin
            state_nxt = ST_DROP;
          end else begin
            state_nxt = ST_ZERO;
          end
        end
      end
      ST_READ: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_DROP: begin
        cmd.drop = 1'b1;
        row_nxt  = RW'(1);
        col_nxt  = RW'(1);
        ph_nxt   = 1'b0;
        state_nxt = has_interior ? ST_SWEEP : ST_DONE;
      end
      ST_SWEEP: begin
        if (!ph_r) begin
          cmd.rd_a = 1'b1;
          ph_nxt   = 1'b1;
        end else begin
          cmd.rd_b = 1'b1;
          ph_nxt   = 1'b0;
          if (col_r == lim) begin
            col_nxt = RW'(1);
            if (row_r == lim) begin
              state_nxt = ST_DRAIN;
            end else begin
              row_nxt = row_r + 1'b1;
            end
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        // wait for the last cell to leave the update pipeline
        ph_nxt = !ph_r;
        if (ph_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        cmd.swap   = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/wrg_dpath.sv
// wrg_dpath: height banks, bank swap, update pipeline and result registers
// depends on wrg_pkg and wrg_bank

module wrg_dpath #(
  parameter int GRID_MAX    = 64,
  parameter int HEIGHT_BITS = 16,
  parameter int ADDR_W      = 12,
  parameter int NW          = 7
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  wrg_pkg::cmd_t                         cmd,
  input  logic [ADDR_W-1:0]                     addr,
  input  logic [NW-1:0]                         n_act,
  input  logic signed [wrg_pkg::DH_W-1:0]       drop_height,
  input  logic                                  in_req_type,
  input  logic                                  in_has_position,
  input  logic signed [wrg_pkg::CELL_W-1:0]     in_cell_col,
  input  logic signed [wrg_pkg::CELL_W-1:0]     in_cell_row,
  output wrg_pkg::stat_t                        st,
  output logic                                  out_valid,
  output logic                                  out_result_kind,
  output logic                                  out_drop_applied,
  output logic signed [wrg_pkg::OUT_H_W-1:0]    out_height
);

  import wrg_pkg::*;

  localparam int CELLS = GRID_MAX * GRID_MAX;
  localparam int RW    = $clog2(GRID_MAX);
  localparam int HB    = HEIGHT_BITS;
  localparam int SW    = HB + 2;
  localparam int RE    = ((HB > OUT_H_W) ? HB : OUT_H_W) + 1;

  localparam logic signed [HB-1:0]      H_MAX = {1'b0, {(HB - 1){1'b1}}};
  localparam logic signed [HB-1:0]      H_MIN = {1'b1, {(HB - 1){1'b0}}};
  localparam logic signed [OUT_H_W-1:0] O_MAX = {1'b0, {(OUT_H_W - 1){1'b1}}};
  localparam logic signed [OUT_H_W-1:0] O_MIN = {1'b1, {(OUT_H_W - 1){1'b0}}};

  // item decode
  logic              in_range;
  logic [ADDR_W-1:0] in_addr;
  logic              kind_r;
  logic              flag_r;
  logic [ADDR_W-1:0] item_addr_r;
  logic              cur_is_b_r;

  // bank ports
  logic              wr_both, wr_cur, wr_prv;
  logic [ADDR_W-1:0] wr_addr;
  logic [HB-1:0]     wr_data;
  logic [ADDR_W-1:0] cur_ra0, cur_ra1, prv_ra;
  logic              a_we, b_we;
  logic [ADDR_W-1:0] a_ra0, b_ra0;
  logic [HB-1:0]     a_rd0, a_rd1, b_rd0, b_rd1;
  logic signed [HB-1:0] cur_d0, cur_d1, prv_d0;

  // update pipeline
  logic                 va_r, vb_r, vh_r;
  logic [ADDR_W-1:0]    pb_r, ph_addr_r;
  logic signed [HB:0]   sum1_r;
  logic signed [HB-1:0] prv_r;
  logic signed [SW-1:0] s_w, half_w, h1_w, h1_r;
  logic signed [SW:0]   h2_w;
  logic signed [HB-1:0] upd_sat;

  // saturations
  logic signed [RE-1:0]      dv, rv;
  logic signed [HB-1:0]      drop_sat;
  logic signed [OUT_H_W-1:0] rd_sat;

  assign in_range = !in_cell_col[CELL_W-1] && !in_cell_row[CELL_W-1] &&
                    ({1'b0, in_cell_col[CELL_W-2:0]} < CELL_W'(n_act)) &&
                    ({1'b0, in_cell_row[CELL_W-2:0]} < CELL_W'(n_act));
  assign in_addr  = ADDR_W'(int'(in_cell_row[RW-1:0]) * GRID_MAX) +
                    ADDR_W'(in_cell_col[RW-1:0]);

  assign st.req_read = (in_req_type == REQ_READ);
  assign st.req_drop = in_has_position && in_range;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r      <= in_req_type;
      flag_r      <= st.req_read ? in_range : st.req_drop;
      item_addr_r <= in_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_is_b_r <= 1'b0;
    end else if (cmd.swap) begin
      cur_is_b_r <= !cur_is_b_r;
    end
  end

  // drop height limited to the stored width
  always_comb begin
    dv = RE'(drop_height);
    if (dv > RE'(H_MAX)) begin
      drop_sat = H_MAX;
    end else if (dv < RE'(H_MIN)) begin
      drop_sat = H_MIN;
    end else begin
      drop_sat = dv[HB-1:0];
    end
  end

  // write and read port selection
  assign wr_both = cmd.clear;
  assign wr_cur  = cmd.drop;
  assign wr_prv  = vh_r;

  always_comb begin
    if (cmd.clear) begin
      wr_addr = addr;
      wr_data = '0;
    end else if (cmd.drop) begin
      wr_addr = item_addr_r;
      wr_data = drop_sat;
    end else begin
      wr_addr = ph_addr_r;
      wr_data = upd_sat;
    end
  end

  always_comb begin
    if (cmd.rd_cell) begin
      cur_ra0 = in_addr;
    end else if (cmd.rd_a) begin
      cur_ra0 = addr - ADDR_W'(GRID_MAX);
    end else begin
      cur_ra0 = addr - 1'b1;
    end
    cur_ra1 = cmd.rd_a ? (addr + ADDR_W'(GRID_MAX)) : (addr + 1'b1);
    prv_ra  = addr;
  end

  assign a_we  = wr_both || (cur_is_b_r ? wr_prv : wr_cur);
  assign b_we  = wr_both || (cur_is_b_r ? wr_cur : wr_prv);
  assign a_ra0 = cur_is_b_r ? prv_ra : cur_ra0;
  assign b_ra0 = cur_is_b_r ? cur_ra0 : prv_ra;

  wrg_bank #(.DEPTH(CELLS), .AW(ADDR_W), .DW(HB)) u_bank_a (
    .clk (clk),
    .we  (a_we),
    .wa  (wr_addr),
    .wd  (wr_data),
    .ra0 (a_ra0),
    .ra1 (cur_ra1),
    .rd0 (a_rd0),
    .rd1 (a_rd1)
  );

  wrg_bank #(.DEPTH(CELLS), .AW(ADDR_W), .DW(HB)) u_bank_b (
    .clk (clk),
    .we  (b_we),
    .wa  (wr_addr),
    .wd  (wr_data),
    .ra0 (b_ra0),
    .ra1 (cur_ra1),
    .rd0 (b_rd0),
    .rd1 (b_rd1)
  );

  assign cur_d0 = $signed(cur_is_b_r ? b_rd0 : a_rd0);
  assign cur_d1 = $signed(cur_is_b_r ? b_rd1 : a_rd1);
  assign prv_d0 = $signed(cur_is_b_r ? a_rd0 : b_rd0);

  // update arithmetic
  assign s_w    = SW'(sum1_r) + SW'(cur_d0) + SW'(cur_d1);
  assign half_w = s_w >>> 1;
  assign h1_w   = half_w - SW'(prv_r);
  assign h2_w   = (SW + 1)'(h1_r) - (SW + 1)'(h1_r >>> DAMP_SHIFT);

  always_comb begin
    if (h2_w > (SW + 1)'(H_MAX)) begin
      upd_sat = H_MAX;
    end else if (h2_w < (SW + 1)'(H_MIN)) begin
      upd_sat = H_MIN;
    end else begin
      upd_sat = h2_w[HB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vh_r <= 1'b0;
    end else begin
      va_r <= cmd.rd_a;
      vb_r <= cmd.rd_b;
      vh_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (va_r) begin
      // vertical pair and previous value arrive in the cycle after issue
      sum1_r <= (HB + 1)'(cur_d0) + (HB + 1)'(cur_d1);
      prv_r  <= prv_d0;
    end
    if (cmd.rd_b) begin
      pb_r <= addr;
    end
    if (vb_r) begin
      h1_r      <= h1_w;
      ph_addr_r <= pb_r;
    end
  end

  // read value limited to the output width
  always_comb begin
    rv = RE'(cur_d0);
    if (rv > RE'(O_MAX)) begin
      rd_sat = O_MAX;
    end else if (rv < RE'(O_MIN)) begin
      rd_sat = O_MIN;
    end else begin
      rd_sat = rv[OUT_H_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_result_kind  <= kind_r;
      out_drop_applied <= flag_r;
      out_height       <= (kind_r == KIND_READ && flag_r) ? rd_sat : '0;
    end
  end

endmodule

>>> src/water_ripple_grid_step.sv
// water_ripple_grid_step: top level of the two-bank water ripple grid
// depends on wrg_pkg, wrg_ctrl, wrg_dpath (and wrg_bank below it)
//
// usage
//   an item is taken at a rising edge with start high and busy low. a step
//   item (in_req_type 0) drops drop_height at (in_cell_row, in_cell_col)
//   when in_has_position is set and the cell is inside the active grid,
//   and updates each interior cell, else clears both banks; either way it
//   swaps the banks. a read item (in_req_type 1) returns one cell height.
//   every item gives one result: out_valid is high for exactly one cycle
//   with out_result_kind, out_drop_applied and out_height; the receiver
//   cannot stall, so nothing waits on the output side.
//   configuration goes through cfg_we / cfg_addr / cfg_wdata while idle.
// sequencing: a read addresses the cell at accept, READ loads the result
//   step with drop: DROP writes the height, SWEEP reads per interior cell
//     the vertical neighbors and previous value, then horizontal ones,
//     since its four neighbors share two bank read ports
//   step that clears: ZERO zeroes both banks, one cell a cycle
//   the result strobe rises at the same edge at which busy falls
// reset
//   rst_n low clears control state; afterwards a clearing pass zeroes all
//   GRID_MAX*GRID_MAX cells of both banks with busy high; registers
//   can still be written during that pass.

module water_ripple_grid_step #(
  parameter int GRID_MAX    = 64,
  parameter int HEIGHT_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // item input
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_req_type,
  input  logic                                  in_has_position,
  input  logic signed [wrg_pkg::CELL_W-1:0]     in_cell_col,
  input  logic signed [wrg_pkg::CELL_W-1:0]     in_cell_row,
  // result output
  output logic                                  out_valid,
  output logic                                  out_result_kind,
  output logic                                  out_drop_applied,
  output logic signed [wrg_pkg::OUT_H_W-1:0]    out_height,
  // configuration writes
  input  logic                                  cfg_we,
  input  logic [wrg_pkg::CFG_AW-1:0]            cfg_addr,
  input  logic [wrg_pkg::CFG_DW-1:0]            cfg_wdata
);

  import wrg_pkg::*;

  localparam int ADDR_W = $clog2(GRID_MAX * GRID_MAX);
  localparam int NW     = $clog2(GRID_MAX + 1);

  logic signed [DH_W-1:0] drop_height_r;
  logic [GS_W-1:0]        grid_size_r;
  logic [NW-1:0]          n_act;
  cmd_t                   cmd;
  stat_t                  st;
  logic [ADDR_W-1:0]      addr;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_height_r <= DROP_RESET;
      grid_size_r   <= GS_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_DROP_HEIGHT: drop_height_r <= $signed(cfg_wdata[DH_W-1:0]);
        CFG_GRID_SIZE:   grid_size_r   <= cfg_wdata[GS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sizes above the storage fall back to the full grid
  assign n_act = (int'(grid_size_r) > GRID_MAX) ? NW'(GRID_MAX) : NW'(grid_size_r);

  wrg_ctrl #(
    .GRID_MAX (GRID_MAX),
    .ADDR_W   (ADDR_W),
    .NW       (NW)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .n_act (n_act),
    .st    (st),
    .cmd   (cmd),
    .addr  (addr)
  );

  wrg_dpath #(
    .GRID_MAX    (GRID_MAX),
    .HEIGHT_BITS (HEIGHT_BITS),
    .ADDR_W      (ADDR_W),
    .NW          (NW)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .addr             (addr),
    .n_act            (n_act),
    .drop_height      (drop_height_r),
    .in_req_type      (in_req_type),
    .in_has_position  (in_has_position),
    .in_cell_col      (in_cell_col),
    .in_cell_row      (in_cell_row),
    .st               (st),
    .out_valid        (out_valid),
    .out_result_kind  (out_result_kind),
    .out_drop_applied (out_drop_applied),
    .out_height       (out_height)
  );

endmodule

>>> src/wrg_checker.sv
// wrg_checker: port-level assertions for the water ripple grid step block
// depends on wrg_pkg; bound to water_ripple_grid_step below

module wrg_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               out_valid,
  input logic                               out_result_kind,
  input logic                               out_drop_applied,
  input logic signed [wrg_pkg::OUT_H_W-1:0] out_height
);

  import wrg_pkg::*;

  // an accepted item always occupies the block
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // one result per item, never two in adjacent cycles
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // a result only follows a busy cycle
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without preceding work");

  // steps report no height
  a_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == KIND_STEP) |-> (out_height == '0))
    else $error("step result carries a height");

  // reads outside the grid report zero
  a_read_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == KIND_READ && !out_drop_applied)
      |-> (out_height == '0))
    else $error("out-of-range read returned a height");

endmodule

bind water_ripple_grid_step wrg_checker u_wrg_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_result_kind  (out_result_kind),
  .out_drop_applied (out_drop_applied),
  .out_height       (out_height)
);

>>> tb/water_ripple_grid_step_test.sv
// water_ripple_grid_step_test: self-checking bench for the two-bank water ripple grid
// depends on wrg_pkg and water_ripple_grid_step; a tracker class mirrors both banks
// and checks every result item in order, plain tasks drive the block

`timescale 1ns / 1ps

module water_ripple_grid_step_test;
  import wrg_pkg::*;

  localparam int GRID_MAX     = 64;
  localparam int HEIGHT_BITS  = 16;
  localparam int CELLS        = GRID_MAX * GRID_MAX;
  // watchdog limit, well above the busy time of a full 64x64 step with a
  // drop and of the clearing pass after reset
  localparam int QUIET_LIMIT  = 40000;
  localparam int RANDOM_ITEMS = 110;

  typedef logic signed [HEIGHT_BITS-1:0] height_t;
  typedef logic signed [CELL_W-1:0]      cell_t;

  typedef struct {
    logic                      kind;
    logic                      applied;
    logic signed [OUT_H_W-1:0] height;
  } ripple_result_t;

  // keeps its own copy of both banks and the registers, works out what
  // every accepted item must return and matches result items in order
  class ripple_tracker;
    height_t                bank [2][CELLS];
    bit                     cur_sel;
    logic signed [DH_W-1:0] drop_height;
    logic [GS_W-1:0]        grid_size;
    ripple_result_t         heights_due [$];
    int                     failures;

    function new();
      foreach (bank[b, i]) bank[b][i] = '0;
      cur_sel     = 1'b0;
      drop_height = DROP_RESET;
      grid_size   = GS_RESET;
      failures    = 0;
    endfunction

    function int active_size();
      return (grid_size > GRID_MAX) ? GRID_MAX : int'(grid_size);
    endfunction

    function void note_register(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
      if (idx == CFG_DROP_HEIGHT) drop_height = data[DH_W-1:0];
      else grid_size = data[GS_W-1:0];
    endfunction

    function height_t saturate(int v);
      int hi;
      int lo;
      hi = (1 <<< (HEIGHT_BITS - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return height_t'(hi);
      if (v < lo) return height_t'(lo);
      return height_t'(v);
    endfunction

    // one wave update over the interior, then the banks trade roles
    function void advance_ripple();
      int n;
      int a;
      int s;
      int h;
      bit prv;
      n   = active_size();
      prv = ~cur_sel;
      for (int r = 1; r + 1 < n; r++) begin
        for (int c = 1; c + 1 < n; c++) begin
          a = r * GRID_MAX + c;
          s = int'(bank[cur_sel][a - GRID_MAX]) + int'(bank[cur_sel][a + GRID_MAX]) +
              int'(bank[cur_sel][a - 1]) + int'(bank[cur_sel][a + 1]);
          h = (s >>> 1) - int'(bank[prv][a]);
          h = h - (h >>> DAMP_SHIFT);
          bank[prv][a] = saturate(h);
        end
      end
      cur_sel = prv;
    endfunction

    function void take_item(logic req, logic has_pos, cell_t col, cell_t row);
      int n;
      int c;
      int r;
      bit in_range;
      ripple_result_t due;
      n = active_size();
      c = col;
      r = row;
      in_range = (c >= 0) && (r >= 0) && (c < n) && (r < n);
      if (req == REQ_READ) begin
        due.kind    = KIND_READ;
        due.applied = in_range;
        due.height  = in_range ? bank[cur_sel][r * GRID_MAX + c] : '0;
      end else begin
        due.kind    = KIND_STEP;
        due.applied = has_pos && in_range;
        due.height  = '0;
        if (due.applied) bank[cur_sel][r * GRID_MAX + c] = saturate(int'(drop_height));
        else foreach (bank[b, i]) bank[b][i] = '0;
        advance_ripple();
      end
      heights_due = {heights_due, due};
    endfunction

    function void match_result(logic kind, logic applied, logic signed [OUT_H_W-1:0] height);
      ripple_result_t due;
      if (heights_due.size() == 0) begin
        $error("result item with no item pending: kind %0d height %0d", kind, height);
        failures++;
        return;
      end
      due = heights_due.pop_front();
      if (kind !== due.kind) begin
        $error("out_result_kind expected %0d got %0d", due.kind, kind);
        failures++;
      end
      if (applied !== due.applied) begin
        $error("out_drop_applied expected %0d got %0d", due.applied, applied);
        failures++;
      end
      if (height !== due.height) begin
        $error("out_height expected %0d got %0d", due.height, height);
        failures++;
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic                      in_req_type;
  logic                      in_has_position;
  cell_t                     in_cell_col;
  cell_t                     in_cell_row;
  logic                      out_valid;
  logic                      out_result_kind;
  logic                      out_drop_applied;
  logic signed [OUT_H_W-1:0] out_height;
  logic                      cfg_we;
  logic [CFG_AW-1:0]         cfg_addr;
  logic [CFG_DW-1:0]         cfg_wdata;

  ripple_tracker tracker;
  int            quiet_cycles;

  water_ripple_grid_step #(
    .GRID_MAX   (GRID_MAX),
    .HEIGHT_BITS(HEIGHT_BITS)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_has_position (in_has_position),
    .in_cell_col     (in_cell_col),
    .in_cell_row     (in_cell_row),
    .out_valid       (out_valid),
    .out_result_kind (out_result_kind),
    .out_drop_applied(out_drop_applied),
    .out_height      (out_height),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata)
  );

  always #10 clk = ~clk;

  // everything the block takes or gives is sampled at the rising edge;
  // results are matched before a new item is noted, since a result never
  // belongs to an item accepted at the same edge
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (out_valid === 1'b1) tracker.match_result(out_result_kind, out_drop_applied, out_height);
      if (start && busy === 1'b0)
        tracker.take_item(in_req_type, in_has_position, in_cell_col, in_cell_row);
      if (cfg_we) tracker.note_register(cfg_addr, cfg_wdata);
    end
  end

  // watchdog: any accepted item, result or register write restarts the count
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (start && busy === 1'b0) || out_valid === 1'b1 || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("water_ripple_grid_step_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // present one item at the falling edge and hold it until busy is seen low
  // at a rising edge; start stays high so the next call can follow directly
  task automatic issue_item(logic req, logic has_pos, int col, int row);
    @(negedge clk);
    start           = 1'b1;
    in_req_type     = req;
    in_has_position = has_pos;
    in_cell_col     = cell_t'(col);
    in_cell_row     = cell_t'(row);
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // sender gap: start low, fields scrambled so that ignored values move too
  task automatic rest_sender(int cycles);
    @(negedge clk);
    start           = 1'b0;
    in_req_type     = 1'($urandom);
    in_has_position = 1'($urandom);
    in_cell_col     = cell_t'($urandom);
    in_cell_row     = cell_t'($urandom);
    repeat (cycles - 1) @(negedge clk);
  endtask

  // block idle: nothing outstanding and busy low
  task automatic drain_items();
    @(negedge clk);
    start = 1'b0;
    do @(posedge clk); while (tracker.heights_due.size() != 0 || busy !== 1'b0);
  endtask

  task automatic program_register(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // grid size upper data bits are junk on purpose, only the low seven count
  task automatic set_registers(int gs, int dh);
    drain_items();
    program_register(CFG_GRID_SIZE, {9'($urandom), 7'(gs)});
    program_register(CFG_DROP_HEIGHT, 16'(dh));
  endtask

  // mostly reads and drops inside the active grid, a few clears, reads
  // and drops anywhere in the 10-bit index range
  task automatic random_item();
    int n;
    int pick;
    int col;
    int row;
    int col_any;
    int row_any;
    n       = tracker.active_size();
    pick    = $urandom_range(0, 99);
    col_any = $urandom_range(0, 1023) - 512;
    row_any = $urandom_range(0, 1023) - 512;
    col     = (n > 0) ? $urandom_range(0, n - 1) : col_any;
    row     = (n > 0) ? $urandom_range(0, n - 1) : row_any;
    if (pick < 45) issue_item(REQ_READ, 1'($urandom), col, row);
    else if (pick < 55) issue_item(REQ_READ, 1'($urandom), col_any, row_any);
    else if (pick < 90) issue_item(REQ_STEP, 1'b1, col, row);
    else if (pick < 95) issue_item(REQ_STEP, 1'b0, col, row);
    else issue_item(REQ_STEP, 1'b1, col_any, row_any);
  endtask

  initial begin
    int sent;
    int gs;
    int dh;
    int phase_len;
    int burst_left;
    tracker         = new();
    rst_n           = 1'b0;
    start           = 1'b0;
    in_req_type     = REQ_STEP;
    in_has_position = 1'b0;
    in_cell_col     = '0;
    in_cell_row     = '0;
    cfg_we          = 1'b0;
    cfg_addr        = CFG_DROP_HEIGHT;
    cfg_wdata       = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // reset settings: full 64 grid, drop height 4096; the first item also
    // waits out the clearing pass
    issue_item(REQ_READ, 1'b0, 0, 0);
    issue_item(REQ_READ, 1'b1, -512, 511);        // read far out of range
    issue_item(REQ_STEP, 1'b1, 32, 32);           // drop in the middle
    issue_item(REQ_READ, 1'b0, 32, 31);           // neighbor after one step
    issue_item(REQ_READ, 1'b1, 511, -1);

    // small grid with the largest drop, saturation likely
    set_registers(4, 32767);
    issue_item(REQ_STEP, 1'b1, 1, 1);
    issue_item(REQ_STEP, 1'b1, 0, 0);             // drop on the border
    issue_item(REQ_STEP, 1'b1, 3, 3);             // far corner, still border
    issue_item(REQ_READ, 1'b0, 2, 1);
    issue_item(REQ_READ, 1'b0, 3, 3);
    issue_item(REQ_STEP, 1'b1, 4, 0);             // drop just outside, clears
    issue_item(REQ_READ, 1'b0, 2, 1);
    issue_item(REQ_STEP, 1'b0, 2, 2);             // no position, clears

    // no interior cells, most negative drop
    set_registers(2, -32768);
    issue_item(REQ_STEP, 1'b1, 1, 1);
    issue_item(REQ_READ, 1'b0, 1, 1);
    issue_item(REQ_READ, 1'b0, 2, 0);

    // empty grid: every cell out of range, a drop turns into a clear
    set_registers(0, 1);
    issue_item(REQ_STEP, 1'b1, 0, 0);
    issue_item(REQ_READ, 1'b0, 0, 0);

    // oversize grid register acts as 64
    set_registers(127, -32768);
    issue_item(REQ_READ, 1'b0, 63, 63);
    issue_item(REQ_STEP, 1'b1, 0, 63);            // border drop on the last row
    issue_item(REQ_READ, 1'b1, 0, 63);
    issue_item(REQ_READ, 1'b0, 64, 0);

    // random phases: mostly small grids, now and then a tiny or full one
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0:       gs = $urandom_range(64, 127);
        1:       gs = $urandom_range(0, 2);
        default: gs = $urandom_range(3, 12);
      endcase
      case ($urandom_range(0, 5))
        0:       dh = 32767;
        1:       dh = -32768;
        default: dh = $urandom_range(0, 65535);
      endcase
      set_registers(gs, dh);
      phase_len  = (gs >= 64) ? 3 : $urandom_range(8, 16);
      burst_left = $urandom_range(1, 8);
      repeat (phase_len) begin
        if (burst_left == 0) begin
          rest_sender($urandom_range(1, 6));
          // now and then a long run with no gaps at all
          burst_left = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(1, 6);
        end
        random_item();
        burst_left--;
        sent++;
      end
    end

    // let the last result land, then watch a little longer for strays
    drain_items();
    repeat (8) @(posedge clk);
    if (tracker.failures == 0) begin
      $display("water_ripple_grid_step_test: done, clean");
    end else begin
      $display("water_ripple_grid_step_test: done, errors");
    end
    $finish;
  end

endmodule
